/* hw/rtl/rll_pkg.sv */
package rll_pkg;

    typedef enum logic [4:0] {
        K_TEXT       = 5'd0,
        K_IDENT      = 5'd1,
        K_RULE       = 5'd2,
        K_FACT       = 5'd3,
        K_COND       = 5'd4,
        K_AND        = 5'd5,
        K_OR         = 5'd6,
        K_NOT        = 5'd7,
        K_DOLLAR     = 5'd8,
        K_LPAREN     = 5'd9,
        K_RPAREN     = 5'd10,
        K_GT         = 5'd11,
        K_GE         = 5'd12,
        K_LT         = 5'd13,
        K_LE         = 5'd14,
        K_EQ         = 5'd15,
        K_NE         = 5'd16,
        K_NUMBER     = 5'd17,
        K_LINE_END   = 5'd18,
        K_BAD_IDENT  = 5'd19,
        K_BAD_NUMBER = 5'd20
    } t_kind;

    typedef struct packed {
        logic [7:0] ch;
        logic       eol;
    } t_in_item;

    typedef struct packed {
        logic [4:0]  kind;
        logic [7:0]  text_char;
        logic [59:0] mantissa;
        logic [4:0]  frac_digits;
        logic        inexact;
        logic        last;
    } t_out_item;

    // keywords packed as big-endian ASCII, right aligned
    localparam logic [31:0] KW_RULE = 32'h5255_4C45;
    localparam logic [31:0] KW_FACT = 32'h4641_4354;
    localparam logic [31:0] KW_COND = 32'h434F_4E44;
    localparam logic [31:0] KW_AND  = 32'h0041_4E44;
    localparam logic [31:0] KW_OR   = 32'h0000_4F52;
    localparam logic [31:0] KW_NOT  = 32'h004E_4F54;

endpackage

/* hw/rtl/rll_stream_if.sv */
interface rll_stream_if #(
    parameter type T = logic
) ();
    logic valid;
    logic ready;
    T     data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

/* hw/rtl/rule_language_lexer.sv */
// An input character passes through the input register and then the result queue before its first result is on o_out.
// Throughput: one character per cycle while the result queue has room; the output side
// moves one result per cycle, so a character that yields two results waits there,
// buffered by a 4-entry result queue (input stalls while fewer than 2 free).
// Reset (i_rst_n low, synchronous): lexer back to idle between tokens, all
// lexer state zero, input register and result queue empty.
module rule_language_lexer #(
    parameter int MAX_DIGITS = 18
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    rll_stream_if.sink      i_in,
    rll_stream_if.source    o_out
);

    typedef enum logic [2:0] {
        M_IDLE  = 3'd0,
        M_SKIP  = 3'd1,
        M_OP    = 3'd2,
        M_IDENT = 3'd3,
        M_NUM   = 3'd4,
        M_WORD  = 3'd5
    } t_mode;

    typedef enum logic [1:0] {
        OP_GT = 2'd0,
        OP_LT = 2'd1,
        OP_EQ = 2'd2,
        OP_NE = 2'd3
    } t_op;

    function automatic logic [59:0] sat_value(input int digits);
        logic [59:0] v;
        v = '0;
        for (int i = 0; i < digits; i++) begin
            v = 60'(v * 60'd10 + 60'd9);
        end
        return v;
    endfunction

    localparam logic [59:0] SAT_NINES = sat_value(MAX_DIGITS);
    localparam logic [4:0]  MAX_D     = 5'(MAX_DIGITS);

    function automatic rll_pkg::t_out_item mk(input rll_pkg::t_kind k,
                                              input logic [7:0] tc);
        rll_pkg::t_out_item r;
        r = '0;
        r.kind = k;
        r.text_char = tc;
        return r;
    endfunction

    function automatic rll_pkg::t_kind word_kind(input logic [31:0] p,
                                                 input logic [2:0] len);
        rll_pkg::t_kind k;
        k = rll_pkg::K_IDENT;
        if (len == 3'd4 && p == rll_pkg::KW_RULE)      k = rll_pkg::K_RULE;
        else if (len == 3'd4 && p == rll_pkg::KW_FACT) k = rll_pkg::K_FACT;
        else if (len == 3'd4 && p == rll_pkg::KW_COND) k = rll_pkg::K_COND;
        else if (len == 3'd3 && p == rll_pkg::KW_AND)  k = rll_pkg::K_AND;
        else if (len == 3'd2 && p == rll_pkg::KW_OR)   k = rll_pkg::K_OR;
        else if (len == 3'd3 && p == rll_pkg::KW_NOT)  k = rll_pkg::K_NOT;
        return k;
    endfunction

    // input register
    logic       r_iv;
    logic [7:0] r_ich;
    logic       r_ieol;

    // lexer state
    t_mode       r_mode, n_mode;
    t_op         r_pend, n_pend;
    logic [59:0] r_num, n_num;
    logic [4:0]  r_frac, n_frac;
    logic [1:0]  r_dots, n_dots;
    logic [4:0]  r_digits, n_digits;
    logic        r_inx, n_inx;
    logic [31:0] r_prefix, n_prefix;
    logic [2:0]  r_wlen, n_wlen;

    // result queue
    rll_pkg::t_out_item r_q [4];
    logic [1:0] r_wr, r_rd;
    logic [2:0] r_cnt;

    logic       adv, pop;
    logic [1:0] push_n;
    rll_pkg::t_out_item res0, res1;

    logic       is_dig, is_wrd;
    logic [3:0] dig;
    logic [59:0] num_x10;

    // first slot: result of the token in progress or closed by this character; second: token it opens or line end
    logic a_v, b_v, use_idle;
    rll_pkg::t_out_item a_item, b_item;

    assign adv        = r_iv && (r_cnt <= 3'd2);
    assign i_in.ready = !r_iv || adv;
    assign pop        = o_out.valid && o_out.ready;
    assign o_out.valid = (r_cnt != 3'd0);
    assign o_out.data  = r_q[r_rd];

    assign is_dig  = (r_ich >= 8'h30) && (r_ich <= 8'h39);
    assign is_wrd  = is_dig || (r_ich >= 8'h41 && r_ich <= 8'h5A)
                     || (r_ich >= 8'h61 && r_ich <= 8'h7A) || (r_ich == 8'h5F);
    assign dig     = r_ich[3:0];
    assign num_x10 = (r_num << 3) + (r_num << 1);

    always_comb begin
        n_mode   = r_mode;
        n_pend   = r_pend;
        n_num    = r_num;
        n_frac   = r_frac;
        n_dots   = r_dots;
        n_digits = r_digits;
        n_inx    = r_inx;
        n_prefix = r_prefix;
        n_wlen   = r_wlen;
        a_v      = 1'b0;
        b_v      = 1'b0;
        a_item   = '0;
        b_item   = '0;
        use_idle = 1'b0;

        if (r_ieol) begin
            unique case (r_mode)
                M_OP: begin
                    a_v    = (r_pend == OP_GT) || (r_pend == OP_LT);
                    a_item = mk((r_pend == OP_GT) ? rll_pkg::K_GT : rll_pkg::K_LT, 8'd0);
                end
                M_IDENT: begin
                    a_v    = 1'b1;
                    a_item = mk(rll_pkg::K_IDENT, 8'd0);
                end
                M_NUM: begin
                    a_v    = 1'b1;
                    a_item = mk(rll_pkg::K_NUMBER, 8'd0);
                    a_item.mantissa    = r_num;
                    a_item.frac_digits = r_frac;
                    a_item.inexact     = r_inx;
                end
                M_WORD: begin
                    a_v    = 1'b1;
                    a_item = mk(word_kind(r_prefix, r_wlen), 8'd0);
                end
                default: ;
            endcase
            b_v    = 1'b1;
            b_item = mk(rll_pkg::K_LINE_END, 8'd0);
            n_mode = M_IDLE;
        end else begin
            unique case (r_mode)
                M_SKIP: ;
                M_OP: begin
                    if (r_ich == 8'h3D) begin
                        a_v = 1'b1;
                        unique case (r_pend)
                            OP_GT: a_item = mk(rll_pkg::K_GE, 8'd0);
                            OP_LT: a_item = mk(rll_pkg::K_LE, 8'd0);
                            OP_EQ: a_item = mk(rll_pkg::K_EQ, 8'd0);
                            OP_NE: a_item = mk(rll_pkg::K_NE, 8'd0);
                            default: a_item = mk(rll_pkg::K_NE, 8'd0);
                        endcase
                        n_mode = M_IDLE;
                    end else begin
                        a_v    = (r_pend == OP_GT) || (r_pend == OP_LT);
                        a_item = mk((r_pend == OP_GT) ? rll_pkg::K_GT : rll_pkg::K_LT,
                                    8'd0);
                        use_idle = 1'b1;
                    end
                end
                M_IDENT: begin
                    a_v = 1'b1;
                    if (r_ich == 8'h20) begin
                        a_item = mk(rll_pkg::K_IDENT, 8'd0);
                        n_mode = M_IDLE;
                    end else if (is_wrd) begin
                        a_item = mk(rll_pkg::K_TEXT, r_ich);
                    end else begin
                        a_item = mk(rll_pkg::K_BAD_IDENT, 8'd0);
                        n_mode = M_SKIP;
                    end
                end
                M_NUM: begin
                    if (r_ich == 8'h20) begin
                        a_v    = 1'b1;
                        a_item = mk(rll_pkg::K_NUMBER, 8'd0);
                        a_item.mantissa    = r_num;
                        a_item.frac_digits = r_frac;
                        a_item.inexact     = r_inx;
                        n_mode = M_IDLE;
                    end else if (is_dig) begin
                        // after the second dot digits are checked but ignored
                        if (r_dots == 2'd0) begin
                            if (r_num == '0 && r_digits == 5'd0 && dig == 4'd0) begin
                                // leading integer zero
                            end else if (r_digits < MAX_D) begin
                                n_num    = num_x10 + 60'(dig);
                                n_digits = r_digits + 5'd1;
                            end else begin
                                n_num  = SAT_NINES;
                                n_frac = 5'd0;
                                n_inx  = 1'b1;
                            end
                        end else if (r_dots == 2'd1) begin
                            if (r_digits < MAX_D) begin
                                n_num    = num_x10 + 60'(dig);
                                n_digits = r_digits + 5'd1;
                                n_frac   = r_frac + 5'd1;
                            end else if (dig != 4'd0) begin
                                n_inx = 1'b1;
                            end
                        end
                    end else if (r_ich == 8'h2E) begin
                        if (r_dots < 2'd2) n_dots = r_dots + 2'd1;
                    end else begin
                        a_v    = 1'b1;
                        a_item = mk(rll_pkg::K_BAD_NUMBER, 8'd0);
                        n_mode = M_SKIP;
                    end
                end
                M_WORD: begin
                    a_v = 1'b1;
                    if (is_wrd) begin
                        if (r_wlen < 3'd4) n_prefix = {r_prefix[23:0], r_ich};
                        if (r_wlen < 3'd5) n_wlen = r_wlen + 3'd1;
                        a_item = mk(rll_pkg::K_TEXT, r_ich);
                    end else begin
                        a_item   = mk(word_kind(r_prefix, r_wlen), 8'd0);
                        use_idle = 1'b1;
                    end
                end
                default: use_idle = 1'b1;
            endcase

            if (use_idle) begin
                n_mode = M_IDLE;
                priority if (r_ich == 8'h20) begin
                end else if (r_ich == 8'h23) begin
                    n_mode = M_SKIP;
                end else if (r_ich == 8'h3E) begin
                    n_mode = M_OP;
                    n_pend = OP_GT;
                end else if (r_ich == 8'h3C) begin
                    n_mode = M_OP;
                    n_pend = OP_LT;
                end else if (r_ich == 8'h3D) begin
                    n_mode = M_OP;
                    n_pend = OP_EQ;
                end else if (r_ich == 8'h21) begin
                    n_mode = M_OP;
                    n_pend = OP_NE;
                end else if (r_ich == 8'h24) begin
                    b_v    = 1'b1;
                    b_item = mk(rll_pkg::K_DOLLAR, 8'd0);
                    n_mode = M_IDENT;
                end else if (r_ich == 8'h28) begin
                    b_v    = 1'b1;
                    b_item = mk(rll_pkg::K_LPAREN, 8'd0);
                end else if (r_ich == 8'h29) begin
                    b_v    = 1'b1;
                    b_item = mk(rll_pkg::K_RPAREN, 8'd0);
                end else if (is_dig) begin
                    n_mode   = M_NUM;
                    n_frac   = 5'd0;
                    n_dots   = 2'd0;
                    n_inx    = 1'b0;
                    n_num    = 60'(dig);
                    n_digits = (dig == 4'd0) ? 5'd0 : 5'd1;
                end else if (is_wrd) begin
                    n_mode   = M_WORD;
                    n_prefix = {24'd0, r_ich};
                    n_wlen   = 3'd1;
                    b_v      = 1'b1;
                    b_item   = mk(rll_pkg::K_TEXT, r_ich);
                end else begin
                end
            end
        end
    end

    // pack the two slots into consecutive results
    always_comb begin
        res0 = a_v ? a_item : b_item;
        res1 = b_item;
        res0.last = !(a_v && b_v);
        res1.last = 1'b1;
        push_n = adv ? (2'(a_v) + 2'(b_v)) : 2'd0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_iv     <= 1'b0;
            r_ich    <= 8'd0;
            r_ieol   <= 1'b0;
            r_mode   <= M_IDLE;
            r_pend   <= OP_GT;
            r_num    <= '0;
            r_frac   <= '0;
            r_dots   <= '0;
            r_digits <= '0;
            r_inx    <= 1'b0;
            r_prefix <= '0;
            r_wlen   <= '0;
            r_wr     <= '0;
            r_rd     <= '0;
            r_cnt    <= '0;
        end else begin
            if (i_in.ready) begin
                r_iv   <= i_in.valid;
                r_ich  <= i_in.data.ch;
                r_ieol <= i_in.data.eol;
            end
            if (adv) begin
                r_mode   <= n_mode;
                r_pend   <= n_pend;
                r_num    <= n_num;
                r_frac   <= n_frac;
                r_dots   <= n_dots;
                r_digits <= n_digits;
                r_inx    <= n_inx;
                r_prefix <= n_prefix;
                r_wlen   <= n_wlen;
            end
            r_wr  <= r_wr + push_n;
            r_rd  <= r_rd + 2'(pop);
            r_cnt <= r_cnt + 3'(push_n) - 3'(pop);
        end
    end

    always_ff @(posedge i_clk) begin
        if (push_n != 2'd0) r_q[r_wr] <= res0;
        if (push_n == 2'd2) r_q[r_wr + 2'd1] <= res1;
    end

    a_queue_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= 3'd4)
        else $error("result queue overflow");

    a_line_end_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && o_out.data.kind == rll_pkg::K_LINE_END) |-> o_out.data.last)
        else $error("line_end not marked last");

    a_eol_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (adv && r_ieol) |=> (r_mode == M_IDLE))
        else $error("mode not idle after end of line");

    a_skip_silent: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (adv && !r_ieol && r_mode == M_SKIP) |-> (push_n == 2'd0))
        else $error("result emitted while skipping line");

    a_pop_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_cnt == 3'd0) |=> (r_cnt <= 3'd2))
        else $error("queue grew by more than one item's results");

endmodule
